// ===== hw/rtl/bcvt_pkg.sv =====
// shared types, constants and the rate table for the breath cycle valve timer
// no dependencies
package bcvt_pkg;

  localparam int unsigned RateW   = 8;
  localparam int unsigned TickW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned QuotW   = 6;   // 60 div rate fits in six bits
  localparam int unsigned NumW    = 13;  // 75 * 60 = 4500 fits in 13 bits
  localparam int unsigned StepW   = 4;
  localparam int unsigned TickLengthReset = 20;

  // period / 4 = 25 * q, period * 3 / 4 = 75 * q
  localparam int unsigned InhaleScale = 25;
  localparam int unsigned ExhaleScale = 75;

  localparam logic [PhaseW-1:0] PhaseNone   = 2'd0;
  localparam logic [PhaseW-1:0] PhaseInhale = 2'd1;
  localparam logic [PhaseW-1:0] PhaseExhale = 2'd2;

  typedef struct packed {
    logic load;    // capture the item and start the divider
    logic step;    // one divider iteration
    logic commit;  // update the breath state and the output item
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

  // 60 div rate, 0 for rate 0 and for rates above 60
  function automatic logic [QuotW-1:0] rate_quot(input logic [RateW-1:0] r);
    logic [QuotW-1:0] q;
    if (r == 8'd0)       q = 6'd0;
    else if (r == 8'd1)  q = 6'd60;
    else if (r == 8'd2)  q = 6'd30;
    else if (r == 8'd3)  q = 6'd20;
    else if (r == 8'd4)  q = 6'd15;
    else if (r == 8'd5)  q = 6'd12;
    else if (r == 8'd6)  q = 6'd10;
    else if (r == 8'd7)  q = 6'd8;
    else if (r == 8'd8)  q = 6'd7;
    else if (r <= 8'd10) q = 6'd6;
    else if (r <= 8'd12) q = 6'd5;
    else if (r <= 8'd15) q = 6'd4;
    else if (r <= 8'd20) q = 6'd3;
    else if (r <= 8'd30) q = 6'd2;
    else if (r <= 8'd60) q = 6'd1;
    else                 q = 6'd0;
    return q;
  endfunction

endpackage

// ===== hw/rtl/breath_cycle_valve_timer.sv =====
// top level of the breath cycle valve timer: controller plus datapath
// depends on bcvt_pkg, bcvt_ctrl and bcvt_datapath
//
//   channel   signals                                      direction
//   input     in_valid_i, in_stall_o, breath_rate_i        item in
//   output    out_valid_o, out_stall_i, open_valves_o,     item out
//             close_valves_o, sound_notify_o, phase_o
//   config    cfg_we_i, cfg_wdata_i (tick_length)          write only
//
// an item goes through a load step, 13 divider iterations (one quotient bit per cycle
// for both phase lengths) and a commit step, and waits longer if the output item is
// still stalled at commit time.
// the next item is taken while a finished item waits at the output.
// reset clears the breath state and sets tick_length to 20.
module breath_cycle_valve_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bcvt_pkg::TickW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bcvt_pkg::RateW-1:0]  breath_rate_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        open_valves_o,
  output logic                        close_valves_o,
  output logic                        sound_notify_o,
  output logic [bcvt_pkg::PhaseW-1:0] phase_o
);

  bcvt_pkg::cmd_t    cmd;
  bcvt_pkg::status_t status;

  bcvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcvt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .breath_rate_i  (breath_rate_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .open_valves_o  (open_valves_o),
    .close_valves_o (close_valves_o),
    .sound_notify_o (sound_notify_o),
    .phase_o        (phase_o)
  );

endmodule

// ===== hw/rtl/bcvt_ctrl.sv =====
// controller for the breath cycle valve timer: sequences load, divide and commit
// and owns the input stall and output valid; depends on bcvt_pkg
module bcvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bcvt_pkg::status_t status_i,
  output bcvt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StFinish
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == StIdle) && in_valid_i;
    cmd_o.step   = (state_q == StDivide);
    cmd_o.commit = (state_q == StFinish) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      // a new item replaces one that leaves in the same cycle
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StDivide;
          end
        end
        StDivide: begin
          if (status_i.last_step) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bcvt_datapath.sv =====
// datapath for the breath cycle valve timer: two-lane restoring divider for the
// phase lengths, breath phase state and the output item register; depends on bcvt_pkg
module bcvt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcvt_pkg::TickW-1:0]    cfg_wdata_i,
  input  logic [bcvt_pkg::RateW-1:0]    breath_rate_i,
  input  bcvt_pkg::cmd_t                cmd_i,
  output bcvt_pkg::status_t             status_o,
  output logic                          open_valves_o,
  output logic                          close_valves_o,
  output logic                          sound_notify_o,
  output logic [bcvt_pkg::PhaseW-1:0]   phase_o
);

  localparam int unsigned NumW   = bcvt_pkg::NumW;
  localparam int unsigned TickW  = bcvt_pkg::TickW;
  localparam int unsigned CountW = bcvt_pkg::CountW;
  localparam int unsigned PhaseW = bcvt_pkg::PhaseW;
  localparam int unsigned StepW  = bcvt_pkg::StepW;
  localparam logic [StepW-1:0] LastStep = StepW'(NumW - 1);

  // configuration
  logic [TickW-1:0] tick_length_q;

  // divider
  logic [TickW-1:0] div_q;
  logic [NumW-1:0]  up_q, dn_q;      // numerator in, quotient out
  logic [TickW-1:0] up_rem_q, dn_rem_q;
  logic [StepW-1:0] step_q;
  logic             running_q;       // nonzero rate for this item
  logic [TickW:0]   up_trial, dn_trial;
  logic             up_ge, dn_ge;
  logic [bcvt_pkg::QuotW-1:0] quot;

  // breath state
  logic [CountW-1:0] inhale_ticks_q, inhale_ticks_d;
  logic [CountW-1:0] exhale_ticks_q, exhale_ticks_d;
  logic              inhale_started_q, inhale_started_d;
  logic              exhale_started_q, exhale_started_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              open_d, close_d, notify_d;

  // output item
  logic              open_q, close_q, notify_q;
  logic [PhaseW-1:0] phase_out_q;

  assign quot = bcvt_pkg::rate_quot(breath_rate_i);

  assign up_trial = {up_rem_q, up_q[NumW-1]};
  assign dn_trial = {dn_rem_q, dn_q[NumW-1]};
  assign up_ge    = (up_trial >= {1'b0, div_q});
  assign dn_ge    = (dn_trial >= {1'b0, div_q});

  assign status_o.last_step = (step_q == LastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_length_q <= TickW'(bcvt_pkg::TickLengthReset);
    end else if (cfg_we_i) begin
      tick_length_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // a zero tick length divides as one
      div_q     <= (tick_length_q == '0) ? TickW'(1) : tick_length_q;
      up_q      <= NumW'(quot * bcvt_pkg::InhaleScale);
      dn_q      <= NumW'(quot * bcvt_pkg::ExhaleScale);
      up_rem_q  <= '0;
      dn_rem_q  <= '0;
      step_q    <= '0;
      running_q <= (breath_rate_i != '0);
    end else if (cmd_i.step) begin
      up_rem_q <= up_ge ? TickW'(up_trial - {1'b0, div_q}) : TickW'(up_trial);
      dn_rem_q <= dn_ge ? TickW'(dn_trial - {1'b0, div_q}) : TickW'(dn_trial);
      up_q     <= {up_q[NumW-2:0], up_ge};
      dn_q     <= {dn_q[NumW-2:0], dn_ge};
      step_q   <= step_q + StepW'(1);
    end
  end

  // one tick of the breath cycle, with up_q and dn_q holding the phase lengths
  always_comb begin
    inhale_ticks_d   = inhale_ticks_q;
    exhale_ticks_d   = exhale_ticks_q;
    inhale_started_d = inhale_started_q;
    exhale_started_d = exhale_started_q;
    phase_d          = phase_q;
    open_d           = 1'b0;
    close_d          = 1'b0;
    notify_d         = 1'b0;
    if (running_q) begin
      inhale_ticks_d = inhale_ticks_q + CountW'(1);
      if (!inhale_started_q) begin
        inhale_started_d = 1'b1;
        open_d           = 1'b1;
        phase_d          = bcvt_pkg::PhaseInhale;
        notify_d         = 1'b1;
        exhale_started_d = 1'b0;
        exhale_ticks_d   = '0;
      end
      if (inhale_ticks_d > CountW'(up_q)) begin
        exhale_ticks_d = exhale_ticks_d + CountW'(1);
        inhale_ticks_d = CountW'(up_q);
        if (!exhale_started_d) begin
          exhale_started_d = 1'b1;
          close_d          = 1'b1;
          phase_d          = bcvt_pkg::PhaseExhale;
          notify_d         = 1'b1;
        end
        if (exhale_ticks_d > CountW'(dn_q)) begin
          inhale_ticks_d   = '0;
          inhale_started_d = 1'b0;
        end
      end
    end else if (inhale_started_q) begin
      // rate dropped to zero: close the valves, no sound notify
      close_d          = 1'b1;
      inhale_started_d = 1'b0;
      exhale_started_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inhale_ticks_q   <= '0;
      exhale_ticks_q   <= '0;
      inhale_started_q <= 1'b0;
      exhale_started_q <= 1'b0;
      phase_q          <= bcvt_pkg::PhaseNone;
    end else if (cmd_i.commit) begin
      inhale_ticks_q   <= inhale_ticks_d;
      exhale_ticks_q   <= exhale_ticks_d;
      inhale_started_q <= inhale_started_d;
      exhale_started_q <= exhale_started_d;
      phase_q          <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      open_q      <= open_d;
      close_q     <= close_d;
      notify_q    <= notify_d;
      phase_out_q <= phase_d;
    end
  end

  assign open_valves_o  = open_q;
  assign close_valves_o = close_q;
  assign sound_notify_o = notify_q;
  assign phase_o        = phase_out_q;

endmodule
